FILE: src/sem_pkg.sv
// sem_pkg: shared types and constants for the sobel edge magnitude block
// no dependencies

package sem_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned POS_W      = 10;
    localparam int unsigned PIX_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // q16 luma weights
    localparam logic [15:0] W_RED   = 16'd19595;
    localparam logic [15:0] W_GREEN = 16'd38470;
    localparam logic [15:0] W_BLUE  = 16'd7471;

    localparam logic [PIX_W-1:0] SAT_VALUE = 8'd255;
    localparam int unsigned ROOT_STEPS = 8;

    typedef struct packed {
        logic accept;
        logic read;
        logic calc;
        logic square;
        logic root_step;
        logic sel_border;
    } t_cmd;

    typedef struct packed {
        logic interior;
        logic border;
        logic root_last;
    } t_status;

endpackage

FILE: src/sem_if.sv
// sem_if: valid/ready channels for pixels, results and configuration writes
// depends on sem_pkg

interface sem_pix_if;
    logic                       valid;
    logic                       ready;
    logic [sem_pkg::PIX_W-1:0]  red;
    logic [sem_pkg::PIX_W-1:0]  green;
    logic [sem_pkg::PIX_W-1:0]  blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface sem_res_if;
    logic                       valid;
    logic                       ready;
    logic [sem_pkg::POS_W-1:0]  out_row;
    logic [sem_pkg::POS_W-1:0]  out_col;
    logic [sem_pkg::PIX_W-1:0]  edge_value;
    logic                       frame_done;
    modport source (output valid, out_row, out_col, edge_value, frame_done, input ready);
    modport sink   (input valid, out_row, out_col, edge_value, frame_done, output ready);
endinterface

interface sem_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sem_pkg::CFG_IDX_W-1:0]  index;
    logic [sem_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/sem_ctrl.sv
// sem_ctrl: per-item sequencer for the sobel block
// depends on sem_pkg

module sem_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pix_valid,
    output logic             o_pix_ready,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    input  sem_pkg::t_status i_status,
    output sem_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_CALC   = 3'd2;
    localparam logic [2:0] S_SQ     = 3'd3;
    localparam logic [2:0] S_ROOT   = 3'd4;
    localparam logic [2:0] S_OUT_IN = 3'd5;
    localparam logic [2:0] S_OUT_BD = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_pix_ready = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pix_ready = 1'b1;
                if (i_pix_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_SQ;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    priority if (i_status.interior) n_state = S_OUT_IN;
                    else if (i_status.border)       n_state = S_OUT_BD;
                    else                            n_state = S_IDLE;
                end
            end
            S_OUT_IN: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = i_status.border ? S_OUT_BD : S_IDLE;
                end
            end
            S_OUT_BD: begin
                o_res_valid      = 1'b1;
                o_cmd.sel_border = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/sem_datapath.sv
// sem_datapath: gray conversion, line stores, 3x3 window, sobel and root unit
// depends on sem_pkg

module sem_datapath #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sem_pkg::t_cmd                  i_cmd,
    output sem_pkg::t_status               o_status,
    input  logic                           i_cfg_wr,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [sem_pkg::PIX_W-1:0]      i_red,
    input  logic [sem_pkg::PIX_W-1:0]      i_green,
    input  logic [sem_pkg::PIX_W-1:0]      i_blue,
    output logic [sem_pkg::POS_W-1:0]      o_out_row,
    output logic [sem_pkg::POS_W-1:0]      o_out_col,
    output logic [sem_pkg::PIX_W-1:0]      o_edge_value,
    output logic                           o_frame_done
);

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned W_RST = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
    localparam int unsigned H_RST = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

    logic [CW-1:0] r_w;
    logic [RW-1:0] r_h;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [AW-1:0] r_c;
    logic [RW-1:0] r_r;
    logic [7:0]    r_red, r_green, r_blue;
    logic [7:0]    r_gray, r_top, r_mid;
    logic [7:0]    r_win [6];
    logic [7:0]    r_older [MAX_WIDTH];
    logic [7:0]    r_newer [MAX_WIDTH];
    logic signed [11:0] r_gx, r_gy;
    logic [21:0]   r_sq;
    logic [7:0]    r_root;
    logic [2:0]    r_step;

    logic [31:0]   cfg32;
    logic [CW-1:0] n_w;
    logic [RW-1:0] n_h;
    logic [CW-1:0] pos_c;
    logic [RW:0]   pos_r;
    logic [CW-1:0] nxt_c;
    logic [RW:0]   nxt_r;
    logic [23:0]   luma;
    logic signed [11:0] p00, p10, p20, p01, p21, p02, p12, p22, gx, gy;
    logic [7:0]    trial;
    logic [15:0]   trial_sq;
    logic [RW-1:0] last_r;
    logic [CW-1:0] last_c;

    // size clamping: zero acts as one, above max acts as max
    always_comb begin
        cfg32 = 32'(i_cfg_data);
        if (cfg32 == 32'd0)           n_w = CW'(1);
        else if (cfg32 > MAX_WIDTH)   n_w = CW'(MAX_WIDTH);
        else                          n_w = CW'(cfg32);
        if (cfg32 == 32'd0)           n_h = RW'(1);
        else if (cfg32 > MAX_HEIGHT)  n_h = RW'(MAX_HEIGHT);
        else                          n_h = RW'(cfg32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= CW'(W_RST);
            r_h <= RW'(H_RST);
        end else if (i_cfg_wr) begin
            if (i_cfg_index == sem_pkg::REG_IMAGE_WIDTH)  r_w <= n_w;
            if (i_cfg_index == sem_pkg::REG_IMAGE_HEIGHT) r_h <= n_h;
        end
    end

    // position of the incoming pixel, with wrap for a shrunk size
    always_comb begin
        if (r_col >= r_w) begin
            pos_c = '0;
            pos_r = {1'b0, r_row} + 1'b1;
        end else begin
            pos_c = r_col;
            pos_r = {1'b0, r_row};
        end
        if (pos_r >= {1'b0, r_h}) pos_r = '0;
        nxt_c = CW'(r_c) + 1'b1;
        nxt_r = {1'b0, r_r} + 1'b1;
        if (nxt_r >= {1'b0, r_h}) nxt_r = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.calc) begin
            if (nxt_c >= r_w) begin
                r_col <= '0;
                r_row <= RW'(nxt_r);
            end else begin
                r_col <= nxt_c;
                r_row <= r_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c     <= AW'(pos_c);
            r_r     <= RW'(pos_r);
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    assign luma = 24'(r_red) * 24'(sem_pkg::W_RED) + 24'(r_green) * 24'(sem_pkg::W_GREEN)
                + 24'(r_blue) * 24'(sem_pkg::W_BLUE);

    // line stores: read on the read step, written after the window uses them
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_top  <= r_older[r_c];
            r_mid  <= r_newer[r_c];
            r_gray <= luma[23:16];
        end
        if (i_cmd.calc) begin
            r_older[r_c] <= r_mid;
            r_newer[r_c] <= r_gray;
        end
    end

    always_comb begin
        p00 = 12'(r_win[0]);
        p10 = 12'(r_win[1]);
        p20 = 12'(r_win[2]);
        p01 = 12'(r_win[3]);
        p21 = 12'(r_win[5]);
        p02 = 12'(r_top);
        p12 = 12'(r_mid);
        p22 = 12'(r_gray);
        gx  = (p02 + (p12 <<< 1) + p22) - (p00 + (p10 <<< 1) + p20);
        gy  = (p20 + (p21 <<< 1) + p22) - (p00 + (p01 <<< 1) + p02);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else if (i_cmd.calc) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_top;
            r_win[4] <= r_mid;
            r_win[5] <= r_gray;
        end
    end

    // bit-serial square root, one result bit per cycle from the top
    assign trial    = r_root | (8'd1 << r_step);
    assign trial_sq = 16'(trial) * 16'(trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_gx <= gx;
            r_gy <= gy;
        end
        if (i_cmd.square) begin
            r_sq   <= 22'(r_gx) * 22'(r_gx) + 22'(r_gy) * 22'(r_gy);
            r_root <= '0;
            r_step <= 3'(sem_pkg::ROOT_STEPS - 1);
        end else if (i_cmd.root_step) begin
            if ({6'd0, trial_sq} <= r_sq) r_root <= trial;
            r_step <= r_step - 1'b1;
        end
    end

    assign last_r = r_h - 1'b1;
    assign last_c = r_w - 1'b1;

    always_comb begin
        o_status.interior  = (r_r >= RW'(2)) && (r_c >= AW'(2));
        o_status.border    = (r_r == '0) || (r_c == '0) || (r_r == last_r)
                          || (CW'(r_c) == last_c);
        o_status.root_last = (r_step == '0);
    end

    always_comb begin
        if (i_cmd.sel_border) begin
            o_out_row    = sem_pkg::POS_W'(r_r);
            o_out_col    = sem_pkg::POS_W'(r_c);
            o_edge_value = r_gray;
            o_frame_done = (r_r == last_r) && (CW'(r_c) == last_c);
        end else begin
            o_out_row    = sem_pkg::POS_W'(r_r - 1'b1);
            o_out_col    = sem_pkg::POS_W'(r_c - 1'b1);
            o_edge_value = (r_sq >= 22'd65536) ? sem_pkg::SAT_VALUE : r_root;
            o_frame_done = 1'b0;
        end
    end

endmodule

FILE: src/sobel_edge_magnitude.sv
// sobel_edge_magnitude: one pixel in, up to two results out per item
// after accept: read, calc and square steps, then the 8-step root unit, then the results
// one item at a time: a new pixel is taken only once every result of the last item is taken
// the block takes no new pixel while a result waits
// reset (synchronous, active low): counters and window cleared, size back to 1024 or the max if smaller
// line stores are not cleared and need no clearing pass

module sobel_edge_magnitude #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sem_pix_if.sink   i_pix,
    sem_res_if.source o_res,
    sem_cfg_if.sink   i_cfg
);

    sem_pkg::t_cmd    cmd;
    sem_pkg::t_status status;

    assign i_cfg.ready = 1'b1;

    sem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix.valid),
        .o_pix_ready (i_pix.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sem_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_wr     (i_cfg.valid & i_cfg.ready),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_red        (i_pix.red),
        .i_green      (i_pix.green),
        .i_blue       (i_pix.blue),
        .o_out_row    (o_res.out_row),
        .o_out_col    (o_res.out_col),
        .o_edge_value (o_res.edge_value),
        .o_frame_done (o_res.frame_done)
    );

endmodule

FILE: src/sem_checker.sv
// sem_checker: port-level assertions for sobel_edge_magnitude, bound to the top
// depends on sobel_edge_magnitude

module sem_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_pix_valid,
    input logic i_pix_ready,
    input logic i_res_valid,
    input logic i_res_ready
);

    // a shown result stays until taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped before taken");

    // one item at a time: no pixel taken while a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_pix_ready)
        else $error("pixel ready while result pending");

    // an accepted item keeps the block busy next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && i_pix_ready |=> !i_pix_ready && !i_res_valid)
        else $error("block not busy after accept");

    // nothing shown right after reset
    assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix.valid),
    .i_pix_ready (i_pix.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready)
);
